// ===== hw/rtl/rte_pkg.sv =====
package rte_pkg;

    localparam int FRAC_BITS = 8;
    localparam int SAMPLE_W  = 13;
    localparam int LIMIT_W   = 15;
    localparam int SHIFT_W   = 3;
    localparam int CNT_W     = 16;
    localparam int EST_W     = SAMPLE_W + FRAC_BITS;
    localparam int TO_W      = LIMIT_W + FRAC_BITS;
    localparam int ADDR_W    = 5;
    localparam int DATA_W    = 32;

    // event kinds on the input channel
    localparam logic [1:0] FUNC_ARM     = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    // register word indexes, paddr[4:2]
    localparam logic [2:0] REG_ALPHA_SHIFT   = 3'd0;
    localparam logic [2:0] REG_BETA_SHIFT    = 3'd1;
    localparam logic [2:0] REG_MAX_SAMPLE    = 3'd2;
    localparam logic [2:0] REG_SMALL_DEFAULT = 3'd3;
    localparam logic [2:0] REG_BACKOFF_LIMIT = 3'd4;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] seq_number;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  timeout_ms;
        logic [SAMPLE_W-1:0] estimated_rtt_ms;
        logic [SAMPLE_W-1:0] deviation_rtt_ms;
        logic [CNT_W-1:0]    timeout_count;
        logic                sample_taken;
    } out_item_t;

    typedef struct packed {
        logic [SHIFT_W-1:0]  alpha_shift;
        logic [SHIFT_W-1:0]  beta_shift;
        logic [SAMPLE_W-1:0] max_sample_ms;
        logic [SAMPLE_W-1:0] small_sample_default_ms;
        logic [LIMIT_W-1:0]  backoff_limit_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_NOP     = 2'd0,
        OP_SAMPLE  = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [SAMPLE_W-1:0] sample;
    } evt_t;

    // move cur toward target by the shifted magnitude of the gap
    function automatic logic [EST_W-1:0] approach(
        input logic [EST_W-1:0]   cur,
        input logic [EST_W-1:0]   target,
        input logic [SHIFT_W-1:0] sh
    );
        logic [EST_W-1:0] res;
        if (target >= cur) begin
            res = cur + ((target - cur) >> sh);
        end else begin
            res = cur - ((cur - target) >> sh);
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/rtt_timeout_estimator.sv =====
// channel   | dir | handshake        | payload
// ----------+-----+------------------+--------------------------------------------
// s_        | in  | s_valid/s_ready  | in_item_t: func, seq_number, now_ms
// m_        | out | m_valid/m_ready  | out_item_t: timeout, est, dev, count, taken
// apb       | in  | psel/penable     | 5 registers at byte addresses 0x00..0x10
//
// one event per cycle sustained while m_ready is high; m_valid rises once an input
// transfer has passed event queue, rtt stage and deviation/timeout stage into m_data
// the feedback loops are the smoothed rtt update and the deviation/timeout/counter update
// synchronous reset clears tracker, estimator state and queue; no clearing pass
// a stalled m_ready backs up the output register, the rtt stage and the 2-entry
// queue before s_ready drops
module rtt_timeout_estimator import rte_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output out_item_t         m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [2:0] reg_idx;

    logic       q_ready;
    logic       q_push;
    evt_t       q_evt;
    logic       q_pop;
    logic       q_not_empty;
    evt_t       q_head;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_ALPHA_SHIFT:   cfg_next.alpha_shift = pwdata[SHIFT_W-1:0];
                REG_BETA_SHIFT:    cfg_next.beta_shift = pwdata[SHIFT_W-1:0];
                REG_MAX_SAMPLE:    cfg_next.max_sample_ms = pwdata[SAMPLE_W-1:0];
                REG_SMALL_DEFAULT: cfg_next.small_sample_default_ms = pwdata[SAMPLE_W-1:0];
                REG_BACKOFF_LIMIT: cfg_next.backoff_limit_ms = pwdata[LIMIT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ALPHA_SHIFT: begin
                prdata = {{(DATA_W-SHIFT_W){1'b0}}, cfg_reg.alpha_shift};
            end
            REG_BETA_SHIFT: begin
                prdata = {{(DATA_W-SHIFT_W){1'b0}}, cfg_reg.beta_shift};
            end
            REG_MAX_SAMPLE: begin
                prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg_reg.max_sample_ms};
            end
            REG_SMALL_DEFAULT: begin
                prdata = {{(DATA_W-SAMPLE_W){1'b0}}, cfg_reg.small_sample_default_ms};
            end
            REG_BACKOFF_LIMIT: begin
                prdata = {{(DATA_W-LIMIT_W){1'b0}}, cfg_reg.backoff_limit_ms};
            end
            default: begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.alpha_shift             <= 3'd3;
            cfg_reg.beta_shift              <= 3'd2;
            cfg_reg.max_sample_ms           <= 13'd5000;
            cfg_reg.small_sample_default_ms <= 13'd1000;
            cfg_reg.backoff_limit_ms        <= 15'd5000;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rte_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_ready (q_ready),
        .q_push  (q_push),
        .q_evt   (q_evt)
    );

    rte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_evt  (q_evt),
        .not_full  (q_ready),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_evt  (q_head)
    );

    rte_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .evt_valid (q_not_empty),
        .evt       (q_head),
        .evt_pop   (q_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== hw/rtl/rte_front.sv =====
module rte_front import rte_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  cfg_t     cfg,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    input  logic     q_ready,
    output logic     q_push,
    output evt_t     q_evt
);

    logic        trk_valid_reg;
    logic        trk_valid_next;
    logic [31:0] trk_seq_reg;
    logic [31:0] trk_seq_next;
    logic [31:0] trk_time_reg;
    logic [31:0] trk_time_next;
    logic [31:0] elapsed;
    logic        accept;
    logic        hit;

    assign s_ready = q_ready;
    assign accept  = s_valid && q_ready;
    assign q_push  = accept;
    assign elapsed = s_data.now_ms - trk_time_reg;
    assign hit     = trk_valid_reg && (trk_seq_reg < s_data.seq_number);

    always_comb begin
        if (elapsed == 32'd0) begin
            q_evt.sample = cfg.small_sample_default_ms;
        end else if (elapsed > {{(32-SAMPLE_W){1'b0}}, cfg.max_sample_ms}) begin
            q_evt.sample = cfg.max_sample_ms;
        end else begin
            q_evt.sample = elapsed[SAMPLE_W-1:0];
        end
        trk_valid_next = trk_valid_reg;
        trk_seq_next   = trk_seq_reg;
        trk_time_next  = trk_time_reg;
        q_evt.op       = OP_NOP;
        unique case (s_data.func)
            FUNC_ARM: begin
                if (accept) begin
                    trk_valid_next = 1'b1;
                    trk_seq_next   = s_data.seq_number;
                    trk_time_next  = s_data.now_ms;
                end
            end
            FUNC_ACK: begin
                if (hit) begin
                    q_evt.op = OP_SAMPLE;
                    if (accept) begin
                        trk_valid_next = 1'b0;
                    end
                end
            end
            FUNC_TIMEOUT: begin
                q_evt.op = OP_TIMEOUT;
            end
            default: begin
                q_evt.op = OP_NOP;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_valid_reg <= 1'b0;
        end else begin
            trk_valid_reg <= trk_valid_next;
        end
        trk_seq_reg  <= trk_seq_next;
        trk_time_reg <= trk_time_next;
    end

endmodule

// ===== hw/rtl/rte_queue.sv =====
module rte_queue import rte_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  evt_t push_evt,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output evt_t head_evt
);

    evt_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign not_full  = (count_reg != 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_evt  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_evt;
        end
    end

endmodule

// ===== hw/rtl/rte_back.sv =====
module rte_back import rte_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      evt_valid,
    input  evt_t      evt,
    output logic      evt_pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    // estimator state
    logic [EST_W-1:0] est_reg;
    logic [EST_W-1:0] est_next;
    logic [EST_W-1:0] dev_reg;
    logic [EST_W-1:0] dev_next;
    logic [TO_W-1:0]  to_reg;
    logic [TO_W-1:0]  to_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    // first stage: smoothed rtt and error
    logic             a_valid_reg;
    logic             a_valid_next;
    op_t              a_op_reg;
    logic             a_first_reg;
    logic [EST_W-1:0] a_err_reg;
    logic [EST_W-1:0] a_s_reg;
    logic [EST_W-1:0] a_est_reg;

    logic             a_ready;
    logic             b_ready;
    logic             b_go;
    logic [EST_W-1:0] s_fix;
    logic             first;
    logic [EST_W-1:0] est_upd;
    logic [EST_W-1:0] err;

    // second stage: deviation, timeout, counter
    logic [EST_W-1:0] dev_upd;
    logic [TO_W:0]    to_sum;
    logic [TO_W-1:0]  to_sum_sat;
    logic [TO_W:0]    to_dbl;
    logic [TO_W-1:0]  to_dbl_sat;
    logic [TO_W-1:0]  to_limit;

    logic             m_valid_reg;
    logic             m_valid_next;
    out_item_t        m_data_reg;
    out_item_t        m_data_next;

    assign b_ready = !m_valid_reg || m_ready;
    assign b_go    = a_valid_reg && b_ready;
    assign a_ready = !a_valid_reg || b_ready;
    assign evt_pop = evt_valid && a_ready;

    assign s_fix   = {evt.sample, {FRAC_BITS{1'b0}}};
    assign first   = (est_reg == '0);
    assign est_upd = first ? s_fix : approach(est_reg, s_fix, cfg.alpha_shift);
    assign err     = (est_upd >= s_fix) ? (est_upd - s_fix) : (s_fix - est_upd);

    always_comb begin
        est_next = est_reg;
        if (evt_pop && (evt.op == OP_SAMPLE)) begin
            est_next = est_upd;
        end
        a_valid_next = evt_pop ? 1'b1 : (b_go ? 1'b0 : a_valid_reg);
    end

    assign dev_upd    = a_first_reg ? (a_s_reg >> 1)
                                    : approach(dev_reg, a_err_reg, cfg.beta_shift);
    assign to_sum     = {{(TO_W+1-EST_W){1'b0}}, a_est_reg}
                      + {{(TO_W-1-EST_W){1'b0}}, dev_upd, 2'b00};
    assign to_sum_sat = to_sum[TO_W] ? {TO_W{1'b1}} : to_sum[TO_W-1:0];
    assign to_dbl     = {to_reg, 1'b0};
    assign to_dbl_sat = to_dbl[TO_W] ? {TO_W{1'b1}} : to_dbl[TO_W-1:0];
    assign to_limit   = {cfg.backoff_limit_ms, {FRAC_BITS{1'b0}}};

    always_comb begin
        dev_next = dev_reg;
        to_next  = to_reg;
        cnt_next = cnt_reg;
        if (b_go) begin
            case (a_op_reg)
                OP_SAMPLE: begin
                    dev_next = dev_upd;
                    to_next  = to_sum_sat;
                end
                OP_TIMEOUT: begin
                    if (to_reg < to_limit) begin
                        to_next = to_dbl_sat;
                    end
                    if (cnt_reg != {CNT_W{1'b1}}) begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        m_data_next = m_data_reg;
        if (b_go) begin
            m_data_next.timeout_ms       = to_next[TO_W-1:FRAC_BITS];
            m_data_next.estimated_rtt_ms = a_est_reg[EST_W-1:FRAC_BITS];
            m_data_next.deviation_rtt_ms = dev_next[EST_W-1:FRAC_BITS];
            m_data_next.timeout_count    = cnt_next;
            m_data_next.sample_taken     = (a_op_reg == OP_SAMPLE);
        end
        m_valid_next = b_go ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            est_reg     <= '0;
            dev_reg     <= '0;
            to_reg      <= '0;
            cnt_reg     <= '0;
            a_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            est_reg     <= est_next;
            dev_reg     <= dev_next;
            to_reg      <= to_next;
            cnt_reg     <= cnt_next;
            a_valid_reg <= a_valid_next;
            m_valid_reg <= m_valid_next;
        end
        if (evt_pop) begin
            a_op_reg    <= evt.op;
            a_first_reg <= first;
            a_err_reg   <= err;
            a_s_reg     <= s_fix;
            a_est_reg   <= est_next;
        end
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
